@@ design/imhq_pkg.sv @@
`timescale 1ns / 1ps
// shared types and codes for the indexed min-heap queue
// no dependencies; compiled first

package imhq_pkg;

	localparam int KIND_W   = 3;
	localparam int VAR_W    = 10;
	localparam int SCORE_W  = 32;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 11;

	localparam logic [KIND_W-1:0] K_ENQ     = 3'd0;
	localparam logic [KIND_W-1:0] K_DEQ     = 3'd1;
	localparam logic [KIND_W-1:0] K_DEL     = 3'd2;
	localparam logic [KIND_W-1:0] K_REPLACE = 3'd3;
	localparam logic [KIND_W-1:0] K_RESCORE = 3'd4;
	localparam logic [KIND_W-1:0] K_FLUSH   = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOTQ    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ALREADY = 3'd4;

	typedef struct packed {
		logic [VAR_W-1:0]          out_var;
		logic signed [SCORE_W-1:0] out_score;
		logic [STATUS_W-1:0]       status;
		logic [OCC_W-1:0]          occupancy;
	} res_t;

endpackage

@@ design/imhq_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for commands and results
// depends on imhq_pkg

interface imhq_in_if;
	logic                               valid;
	logic                               ready;
	logic [imhq_pkg::KIND_W-1:0]        kind;
	logic [imhq_pkg::VAR_W-1:0]         var_id;
	logic signed [imhq_pkg::SCORE_W-1:0] key_score;

	modport source (output valid, kind, var_id, key_score, input ready);
	modport sink (input valid, kind, var_id, key_score, output ready);
endinterface

interface imhq_out_if;
	logic                                valid;
	logic                                ready;
	logic [imhq_pkg::VAR_W-1:0]          out_var;
	logic signed [imhq_pkg::SCORE_W-1:0] out_score;
	logic [imhq_pkg::STATUS_W-1:0]       status;
	logic [imhq_pkg::OCC_W-1:0]          occupancy;

	modport source (output valid, out_var, out_score, status, occupancy, input ready);
	modport sink (input valid, out_var, out_score, status, occupancy, output ready);
endinterface

@@ design/imhq_cmp.sv @@
`timescale 1ns / 1ps
// shared signed score comparator used by every sift step
// depends on imhq_pkg

module imhq_cmp (
	input  logic signed [imhq_pkg::SCORE_W-1:0] a,
	input  logic signed [imhq_pkg::SCORE_W-1:0] b,
	output logic                                gt
);
	import imhq_pkg::*;

	assign gt = (a > b);

endmodule

@@ design/imhq_core.sv @@
`timescale 1ns / 1ps
// heap, position map and score memories with the operation sequencer
// depends on imhq_pkg, imhq_if and imhq_cmp

module imhq_core #(
	parameter int NUM_VARS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	imhq_in_if.sink        in_ch,
	output imhq_pkg::res_t res,
	output logic           res_valid,
	input  logic           res_ready
);
	import imhq_pkg::*;

	localparam int AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
	localparam int SW = $clog2(NUM_VARS + 1);

	typedef enum logic [24:0] {
		S_CLR    = 25'h0000001,
		S_IDLE   = 25'h0000002,
		S_DEC    = 25'h0000004,
		S_DQ2    = 25'h0000008,
		S_DQ3    = 25'h0000010,
		S_DL1    = 25'h0000020,
		S_DL2    = 25'h0000040,
		S_DL3    = 25'h0000080,
		S_DL4    = 25'h0000100,
		S_DL5    = 25'h0000200,
		S_RR1    = 25'h0000400,
		S_RS1    = 25'h0000800,
		S_FLUSH  = 25'h0001000,
		S_SU_CHK = 25'h0002000,
		S_SU_RDP = 25'h0004000,
		S_SU_CMP = 25'h0008000,
		S_SD_CHK = 25'h0010000,
		S_SD_RL  = 25'h0020000,
		S_SD_RR  = 25'h0040000,
		S_SD_SL  = 25'h0080000,
		S_SD_SR  = 25'h0100000,
		S_SD_LO  = 25'h0200000,
		S_SD_CMP = 25'h0400000,
		S_PLACE  = 25'h0800000,
		S_FIN    = 25'h1000000
	} state_t;

	function automatic logic [AW-1:0] vidx(input logic [VAR_W-1:0] v);
		return AW'(v);
	endfunction

	function automatic logic [AW-1:0] padr(input logic [SW:0] p);
		logic [SW:0] t;
		t = p - 1'b1;
		return AW'(t);
	endfunction

	// memories
	logic [VAR_W-1:0]          heap_mem [NUM_VARS];
	logic [SW-1:0]             slot_mem [NUM_VARS];
	logic signed [SCORE_W-1:0] score_mem [NUM_VARS];

	logic                      heap_we, slot_we, score_we;
	logic [AW-1:0]             heap_wa, slot_wa, score_wa;
	logic [AW-1:0]             heap_ra, slot_ra, score_ra;
	logic [VAR_W-1:0]          heap_wd;
	logic [SW-1:0]             slot_wd;
	logic signed [SCORE_W-1:0] score_wd;
	logic [VAR_W-1:0]          heap_rd_q;
	logic [SW-1:0]             slot_rd_q;
	logic signed [SCORE_W-1:0] score_rd_q;

	always_ff @(posedge clk) begin
		if (heap_we) heap_mem[heap_wa] <= heap_wd;
		heap_rd_q <= heap_mem[heap_ra];
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_wa] <= slot_wd;
		slot_rd_q <= slot_mem[slot_ra];
	end

	always_ff @(posedge clk) begin
		if (score_we) score_mem[score_wa] <= score_wd;
		score_rd_q <= score_mem[score_ra];
	end

	// sequencer registers
	state_t                    state_q, state_d;
	logic [SW-1:0]             fill_q, fill_d;
	logic [AW-1:0]             clr_q, clr_d;
	logic [SW-1:0]             i_q, i_d;
	logic                      fv_q, fv_d;
	logic [KIND_W-1:0]         kind_q, kind_d;
	logic [VAR_W-1:0]          var_q, var_d;
	logic signed [SCORE_W-1:0] key_q, key_d;
	logic                      vok_q, vok_d;
	logic [SW-1:0]             pos_q, pos_d;
	logic [SW:0]               c_q, c_d;
	logic [VAR_W-1:0]          mv_q, mv_d, pv_q, pv_d, lv_q, lv_d, rv_q, rv_d, cv_q, cv_d;
	logic signed [SCORE_W-1:0] ms_q, ms_d, ls_q, ls_d, cs_q, cs_d;
	logic [VAR_W-1:0]          ov_q, ov_d;
	logic signed [SCORE_W-1:0] os_q, os_d;
	logic [STATUS_W-1:0]       st_q, st_d;

	logic signed [SCORE_W-1:0] cmp_a, cmp_b;
	logic                      cmp_gt;
	logic [SW:0]               pos_x, fill_x, c_new;
	logic [SW-1:0]             par;

	imhq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .gt(cmp_gt));

	assign pos_x  = {1'b0, pos_q};
	assign fill_x = {1'b0, fill_q};
	assign c_new  = {pos_q, 1'b0};
	assign par    = pos_q >> 1;

	always_comb begin
		unique case (state_q)
			S_SU_CMP: begin cmp_a = score_rd_q; cmp_b = ms_q; end
			S_SD_SR:  begin cmp_a = ls_q;       cmp_b = score_rd_q; end
			S_DL5:    begin cmp_a = score_rd_q; cmp_b = ms_q; end
			S_RS1:    begin cmp_a = score_rd_q; cmp_b = key_q; end
			default:  begin cmp_a = ms_q;       cmp_b = cs_q; end
		endcase
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign res_valid   = (state_q == S_FIN);
	assign res.out_var   = ov_q;
	assign res.out_score = os_q;
	assign res.status    = st_q;
	assign res.occupancy = OCC_W'(fill_q);

	always_comb begin
		state_d = state_q; fill_d = fill_q; clr_d = clr_q; i_d = i_q; fv_d = fv_q;
		kind_d = kind_q; var_d = var_q; key_d = key_q; vok_d = vok_q;
		pos_d = pos_q; c_d = c_q; mv_d = mv_q; pv_d = pv_q; lv_d = lv_q; rv_d = rv_q;
		cv_d = cv_q; ms_d = ms_q; ls_d = ls_q; cs_d = cs_q;
		ov_d = ov_q; os_d = os_q; st_d = st_q;
		heap_we = 1'b0; heap_wa = '0; heap_wd = '0; heap_ra = '0;
		slot_we = 1'b0; slot_wa = '0; slot_wd = '0; slot_ra = '0;
		score_we = 1'b0; score_wa = '0; score_wd = '0; score_ra = '0;

		unique case (state_q)
			S_CLR: begin
				// position map sweep after reset
				slot_we = 1'b1;
				slot_wa = clr_q;
				clr_d   = clr_q + 1'b1;
				if (clr_q == AW'(NUM_VARS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				slot_ra = vidx(in_ch.var_id);
				if (in_ch.valid) begin
					kind_d  = in_ch.kind;
					var_d   = in_ch.var_id;
					key_d   = in_ch.key_score;
					vok_d   = (32'(in_ch.var_id) < NUM_VARS);
					ov_d    = '0;
					os_d    = '0;
					st_d    = ST_OK;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				priority if (kind_q == K_ENQ || kind_q == K_REPLACE || kind_q == K_RESCORE) begin
					if (!vok_q) begin
						st_d = ST_NOTQ; state_d = S_FIN;
					end else if (slot_rd_q != '0) begin
						if (kind_q == K_RESCORE) begin
							pos_d = slot_rd_q; score_ra = vidx(var_q); state_d = S_RS1;
						end else begin
							st_d = ST_ALREADY; state_d = S_FIN;
						end
					end else if (kind_q == K_REPLACE && fill_q != '0) begin
						ov_d = heap_rd_q; score_ra = vidx(heap_rd_q); state_d = S_RR1;
					end else if (32'(fill_q) >= NUM_VARS) begin
						st_d = ST_FULL; state_d = S_FIN;
					end else begin
						// enqueue at the tail and sift up
						score_we = 1'b1; score_wa = vidx(var_q); score_wd = key_q;
						fill_d = fill_q + 1'b1;
						pos_d  = fill_q + 1'b1;
						mv_d   = var_q;
						ms_d   = key_q;
						state_d = S_SU_CHK;
					end
				end else if (kind_q == K_DEQ) begin
					if (fill_q == '0) begin
						st_d = ST_EMPTY; state_d = S_FIN;
					end else begin
						ov_d = heap_rd_q;
						score_ra = vidx(heap_rd_q);
						heap_ra = padr(fill_x);
						state_d = S_DQ2;
					end
				end else if (kind_q == K_DEL) begin
					if (!vok_q || slot_rd_q == '0) begin
						st_d = ST_NOTQ; state_d = S_FIN;
					end else begin
						pos_d = slot_rd_q; score_ra = vidx(var_q); state_d = S_DL1;
					end
				end else if (kind_q == K_FLUSH) begin
					i_d = '0; fv_d = 1'b0; state_d = S_FLUSH;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DQ2: begin
				os_d = score_rd_q;
				slot_we = 1'b1; slot_wa = vidx(ov_q); slot_wd = '0;
				fill_d = fill_q - 1'b1;
				if (fill_q == SW'(1)) begin
					state_d = S_FIN;
				end else begin
					mv_d = heap_rd_q; pos_d = SW'(1);
					score_ra = vidx(heap_rd_q);
					state_d = S_DQ3;
				end
			end
			S_DQ3: begin
				ms_d = score_rd_q; state_d = S_SD_CHK;
			end
			S_DL1: begin
				os_d = score_rd_q; ov_d = var_q;
				slot_we = 1'b1; slot_wa = vidx(var_q); slot_wd = '0;
				if (pos_q == fill_q) begin
					fill_d = fill_q - 1'b1; state_d = S_FIN;
				end else begin
					heap_ra = padr(fill_x); state_d = S_DL2;
				end
			end
			S_DL2: begin
				fill_d = fill_q - 1'b1;
				mv_d = heap_rd_q;
				score_ra = vidx(heap_rd_q);
				state_d = S_DL3;
			end
			S_DL3: begin
				ms_d = score_rd_q;
				if (pos_q > SW'(1)) begin
					heap_ra = padr({1'b0, par}); state_d = S_DL4;
				end else begin
					state_d = S_SD_CHK;
				end
			end
			S_DL4: begin
				score_ra = vidx(heap_rd_q); state_d = S_DL5;
			end
			S_DL5: begin
				state_d = cmp_gt ? S_SU_CHK : S_SD_CHK;
			end
			S_RR1: begin
				os_d = score_rd_q;
				slot_we = 1'b1; slot_wa = vidx(ov_q); slot_wd = '0;
				score_we = 1'b1; score_wa = vidx(var_q); score_wd = key_q;
				mv_d = var_q; ms_d = key_q; pos_d = SW'(1);
				state_d = S_SD_CHK;
			end
			S_RS1: begin
				score_we = 1'b1; score_wa = vidx(var_q); score_wd = key_q;
				mv_d = var_q; ms_d = key_q;
				state_d = cmp_gt ? S_SU_CHK : S_SD_CHK;
			end
			S_FLUSH: begin
				// read a heap slot, clear its map entry once the read data returns
				if (fv_q) begin
					slot_we = 1'b1; slot_wa = vidx(heap_rd_q); slot_wd = '0;
				end
				if (i_q < fill_q) begin
					heap_ra = AW'(i_q); i_d = i_q + 1'b1; fv_d = 1'b1;
				end else begin
					fv_d = 1'b0;
					if (!fv_q) begin
						fill_d = '0; state_d = S_FIN;
					end
				end
			end
			S_SU_CHK: begin
				if (pos_q <= SW'(1)) begin
					state_d = S_PLACE;
				end else begin
					heap_ra = padr({1'b0, par}); state_d = S_SU_RDP;
				end
			end
			S_SU_RDP: begin
				pv_d = heap_rd_q; score_ra = vidx(heap_rd_q); state_d = S_SU_CMP;
			end
			S_SU_CMP: begin
				if (cmp_gt) begin
					heap_we = 1'b1; heap_wa = padr(pos_x); heap_wd = pv_q;
					slot_we = 1'b1; slot_wa = vidx(pv_q); slot_wd = pos_q;
					pos_d = par;
					state_d = S_SU_CHK;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_SD_CHK: begin
				if (c_new > fill_x) begin
					state_d = S_PLACE;
				end else begin
					c_d = c_new; heap_ra = padr(c_new); state_d = S_SD_RL;
				end
			end
			S_SD_RL: begin
				lv_d = heap_rd_q;
				if (c_q + 1'b1 <= fill_x) begin
					heap_ra = AW'(c_q); state_d = S_SD_RR;
				end else begin
					score_ra = vidx(heap_rd_q); state_d = S_SD_LO;
				end
			end
			S_SD_LO: begin
				cs_d = score_rd_q; cv_d = lv_q; state_d = S_SD_CMP;
			end
			S_SD_RR: begin
				rv_d = heap_rd_q; score_ra = vidx(lv_q); state_d = S_SD_SL;
			end
			S_SD_SL: begin
				ls_d = score_rd_q; score_ra = vidx(rv_q); state_d = S_SD_SR;
			end
			S_SD_SR: begin
				// left child wins ties
				if (cmp_gt) begin
					cs_d = score_rd_q; cv_d = rv_q; c_d = c_q + 1'b1;
				end else begin
					cs_d = ls_q; cv_d = lv_q;
				end
				state_d = S_SD_CMP;
			end
			S_SD_CMP: begin
				if (cmp_gt) begin
					heap_we = 1'b1; heap_wa = padr(pos_x); heap_wd = cv_q;
					slot_we = 1'b1; slot_wa = vidx(cv_q); slot_wd = pos_q;
					pos_d = SW'(c_q);
					state_d = S_SD_CHK;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				heap_we = 1'b1; heap_wa = padr(pos_x); heap_wd = mv_q;
				slot_we = 1'b1; slot_wa = vidx(mv_q); slot_wd = pos_q;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			fill_q  <= '0;
			clr_q   <= '0;
			i_q     <= '0;
			fv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			clr_q   <= clr_d;
			i_q     <= i_d;
			fv_q    <= fv_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d; var_q <= var_d; key_q <= key_d; vok_q <= vok_d;
		pos_q <= pos_d; c_q <= c_d; mv_q <= mv_d; pv_q <= pv_d; lv_q <= lv_d;
		rv_q <= rv_d; cv_q <= cv_d; ms_q <= ms_d; ls_q <= ls_d; cs_q <= cs_d;
		ov_q <= ov_d; os_q <= os_d; st_q <= st_d;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= NUM_VARS)
		else $error("heap fill beyond capacity");

	a_place_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PLACE |-> (pos_q != '0 && pos_q <= fill_q))
		else $error("placement outside the heap");

	a_child_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SD_CMP |-> (c_q <= fill_x && c_q > pos_x))
		else $error("sift-down child outside the heap");

endmodule

@@ design/indexed_min_heap_queue_top.sv @@
`timescale 1ns / 1ps
// top level: command channel, sequencer core and result register
// depends on imhq_pkg, imhq_if and imhq_core
//
// usage:
//   in_ch carries one command beat (kind, var_id, key_score); out_ch returns
//   exactly one result beat per command (out_var, out_score, status, occupancy).
//   in_ch.ready is high only while the sequencer is idle; one command is in
//   flight at a time.
//   operations run as a sequence of states: set-up, then a sift-up or sift-down
//   loop over the heap levels, then placement; flag-only answers skip the sift,
//   and flush walks every filled heap slot. The single read and write port of
//   each memory and the shared score comparator set this sequencing.
//   reset: the queue is empty; the position map is then swept, one entry per
//   cycle, and in_ch.ready stays low during the sweep.
//   stall: the result sits in an output register; the next command is taken
//   while it waits, and the core holds its next result until the register
//   frees up.

module indexed_min_heap_queue_top #(
	parameter int NUM_VARS = 1024
) (
	input logic        clk,
	input logic        arst_n,
	imhq_in_if.sink    in_ch,
	imhq_out_if.source out_ch
);
	import imhq_pkg::*;

	res_t res;
	logic res_valid;
	logic res_ready;
	logic ovalid_q;
	res_t out_q;

	imhq_core #(.NUM_VARS(NUM_VARS)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.res(res),
		.res_valid(res_valid),
		.res_ready(res_ready)
	);

	assign res_ready = !ovalid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_ready) begin
			ovalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_q <= res;
	end

	assign out_ch.valid     = ovalid_q;
	assign out_ch.out_var   = out_q.out_var;
	assign out_ch.out_score = out_q.out_score;
	assign out_ch.status    = out_q.status;
	assign out_ch.occupancy = out_q.occupancy;

endmodule
